### hw/rtl/bfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_pkg
// Shared types and constants of the interpreter core.
// ----------------------------------------------------------------------------
package bfi_pkg;

  localparam int unsigned AddrW = 12;
  localparam int unsigned PcW   = 13;
  localparam int unsigned CellW = 32;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChRight = 8'h3E;
  localparam logic [7:0] ChLeft  = 8'h3C;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;

  localparam logic [1:0] Mode8  = 2'd0;
  localparam logic [1:0] Mode16 = 2'd1;

  localparam logic CfgLastIndex = 1'b0;
  localparam logic CfgCellMode  = 1'b1;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqStep = 1'b1;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StOpenErr   = 3'd1,
    StCloseErr  = 3'd2,
    StLeftZero  = 3'd3,
    StUnknown   = 3'd4,
    StOverflow  = 3'd5
  } status_e;

  typedef struct packed {
    logic             req_type;
    logic [AddrW-1:0] load_address;
    logic [7:0]       load_char;
    logic [7:0]       in_char;
    logic             in_end;
  } req_t;

  typedef struct packed {
    logic             out_valid;
    logic [7:0]       out_char;
    logic             halted;
    logic [2:0]       status;
    logic [PcW-1:0]   next_pc;
    logic [AddrW-1:0] cell_pointer_out;
  } rsp_t;

  typedef struct packed {
    logic             valid;
    req_t             item;
  } qhead_t;

  function automatic logic [CellW-1:0] width_mask(input logic [1:0] mode);
    logic [CellW-1:0] m;
    case (mode)
      Mode8:   m = 32'h0000_00FF;
      Mode16:  m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### hw/rtl/bfi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_if
// Handshake channels: request, response and configuration write.
// ----------------------------------------------------------------------------
interface bfi_req_if;
  logic          valid;
  logic          ready;
  bfi_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfi_rsp_if;
  logic          valid;
  logic          ready;
  bfi_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bfi_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [11:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

### hw/rtl/bfi_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### hw/rtl/bfi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_front
// Accepts request items and queues them, tagged load or step, in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module bfi_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            open_i,
  bfi_req_if.sink         req_i,
  input  logic            pop_i,
  output bfi_pkg::qhead_t head_o
);
  bfi_pkg::req_t slot_q [2];
  logic [1:0]    cnt_q;
  logic          rd_q, wr_q;
  logic          push;

  assign req_i.ready = open_i && (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= req_i.data;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = slot_q[rd_q];
endmodule

### hw/rtl/bfi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_back
// Execution side: program store, tape, bracket scanner and result register.
// ----------------------------------------------------------------------------
module bfi_back #(
  parameter int unsigned PROG_DEPTH = 4096,
  parameter int unsigned TAPE_CELLS = 4096
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfi_pkg::qhead_t head_i,
  output logic            pop_o,
  output logic            ready_o,
  bfi_cfg_if.sink         cfg_i,
  bfi_rsp_if.source       rsp_o
);
  localparam int unsigned PaW = $clog2(PROG_DEPTH);
  localparam int unsigned TaW = $clog2(TAPE_CELLS);
  localparam int unsigned PcW = bfi_pkg::PcW;

  typedef enum logic [2:0] {
    SClear, SIdle, SExec, SScanRd, SScanChk, SPush
  } state_e;

  state_e                  state_q;
  logic [11:0]             last_q;
  logic [1:0]              mode_q;
  logic [PcW-1:0]          pc_q, p_q;
  logic [TaW-1:0]          ptr_q;
  logic [TaW:0]            clr_q;
  logic                    err_q, fwd_q, zero_q;
  bfi_pkg::status_e        code_q, st_q;
  logic [PcW-1:0]          depth_q;
  logic                    ov_q;
  logic [7:0]              oc_q;
  bfi_pkg::req_t           ent_q;
  bfi_pkg::rsp_t           rsp_q;
  logic                    rvld_q;

  logic [7:0]              pchar, ch;
  logic [PcW-1:0]          prd_pc, p_nx;
  logic                    p_we;
  logic [31:0]             t_rdata, t_wdata, cur_cell, mask;
  logic                    t_we;
  logic [TaW-1:0]          t_waddr;
  logic [PcW-1:0]          last_ext;
  logic                    at_last;

  assign last_ext = PcW'(last_q);
  assign mask     = bfi_pkg::width_mask(mode_q);
  assign cur_cell = t_rdata & mask;
  assign ch       = zero_q ? 8'h00 : pchar;
  assign at_last  = (pc_q == last_ext);
  assign p_nx     = fwd_q ? (p_q + PcW'(1)) : (p_q - PcW'(1));

  assign ready_o     = (state_q != SClear);
  assign cfg_i.ready = 1'b1;
  assign pop_o       = (state_q == SIdle) && head_i.valid;

  // program store: loads write, execution and scans read
  assign p_we   = pop_o && (head_i.item.req_type == bfi_pkg::ReqLoad)
                  && (32'(head_i.item.load_address) < PROG_DEPTH);
  assign prd_pc = (state_q == SScanRd) ? p_nx : pc_q;

  bfi_ram #(.Width(8), .Depth(PROG_DEPTH)) u_prog (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (PaW'(head_i.item.load_address)),
    .wdata_i (head_i.item.load_char),
    .raddr_i (PaW'(prd_pc)),
    .rdata_o (pchar)
  );

  always_comb begin
    t_we    = 1'b0;
    t_wdata = '0;
    t_waddr = ptr_q;
    if (state_q == SClear) begin
      t_we    = 1'b1;
      t_waddr = clr_q[TaW-1:0];
    end else if (state_q == SExec) begin
      case (ch)
        bfi_pkg::ChPlus: begin
          t_we    = 1'b1;
          t_wdata = (cur_cell + 32'd1) & mask;
        end
        bfi_pkg::ChMinus: begin
          t_we    = 1'b1;
          t_wdata = (cur_cell - 32'd1) & mask;
        end
        bfi_pkg::ChComma: begin
          t_we    = 1'b1;
          t_wdata = ent_q.in_end ? mask : (32'(ent_q.in_char) & mask);
        end
        default: t_we = 1'b0;
      endcase
    end
  end

  bfi_ram #(.Width(32), .Depth(TAPE_CELLS)) u_tape (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (ptr_q),
    .rdata_o (t_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      clr_q   <= '0;
      last_q  <= '0;
      mode_q  <= '0;
      pc_q    <= '0;
      ptr_q   <= '0;
      err_q   <= 1'b0;
      code_q  <= bfi_pkg::StOk;
      st_q    <= bfi_pkg::StOk;
      rvld_q  <= 1'b0;
      fwd_q   <= 1'b0;
      zero_q  <= 1'b0;
      depth_q <= '0;
      p_q     <= '0;
      ov_q    <= 1'b0;
      oc_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          bfi_pkg::CfgLastIndex: last_q <= cfg_i.wdata;
          bfi_pkg::CfgCellMode:  mode_q <= cfg_i.wdata[1:0];
          default: ;
        endcase
      end
      if (rsp_o.ready) begin
        rvld_q <= 1'b0;
      end
      case (state_q)
        SClear: begin
          clr_q <= clr_q + (TaW+1)'(1);
          if (32'(clr_q) == TAPE_CELLS - 1) begin
            state_q <= SIdle;
          end
        end
        SIdle: begin
          if (head_i.valid) begin
            st_q  <= bfi_pkg::StOk;
            ov_q  <= 1'b0;
            oc_q  <= '0;
            if (head_i.item.req_type == bfi_pkg::ReqLoad) begin
              state_q <= SPush;
            end else if (err_q) begin
              st_q    <= code_q;
              state_q <= SPush;
            end else if (pc_q > last_ext) begin
              state_q <= SPush;
            end else begin
              zero_q  <= !(32'(pc_q) < PROG_DEPTH);
              state_q <= SExec;
            end
          end
        end
        SExec: begin
          state_q <= SPush;
          pc_q    <= pc_q + PcW'(1);
          case (ch)
            bfi_pkg::ChPlus, bfi_pkg::ChMinus, bfi_pkg::ChComma: ;
            bfi_pkg::ChRight: begin
              if (32'(ptr_q) == TAPE_CELLS - 1) st_q <= bfi_pkg::StOverflow;
              else ptr_q <= ptr_q + TaW'(1);
            end
            bfi_pkg::ChLeft: begin
              if (ptr_q == '0) st_q <= bfi_pkg::StLeftZero;
              else ptr_q <= ptr_q - TaW'(1);
            end
            bfi_pkg::ChDot: begin
              ov_q <= 1'b1;
              oc_q <= cur_cell[7:0];
            end
            bfi_pkg::ChOpen: begin
              if (at_last) begin
                // no room for a match, whatever the cell holds
                pc_q   <= pc_q;
                st_q   <= bfi_pkg::StOpenErr;
                err_q  <= 1'b1;
                code_q <= bfi_pkg::StOpenErr;
              end else if (cur_cell == '0) begin
                pc_q    <= pc_q;
                p_q     <= pc_q;
                fwd_q   <= 1'b1;
                depth_q <= '0;
                state_q <= SScanRd;
              end
            end
            bfi_pkg::ChClose: begin
              if (pc_q == '0) begin
                pc_q   <= pc_q;
                st_q   <= bfi_pkg::StCloseErr;
                err_q  <= 1'b1;
                code_q <= bfi_pkg::StCloseErr;
              end else if (cur_cell != '0) begin
                pc_q    <= pc_q;
                p_q     <= pc_q;
                fwd_q   <= 1'b0;
                depth_q <= '0;
                state_q <= SScanRd;
              end
            end
            default: st_q <= bfi_pkg::StUnknown;
          endcase
        end
        SScanRd: begin
          p_q     <= p_nx;
          zero_q  <= !(32'(p_nx) < PROG_DEPTH);
          state_q <= SScanChk;
        end
        SScanChk: begin
          if ((fwd_q && ch == bfi_pkg::ChOpen) || (!fwd_q && ch == bfi_pkg::ChClose)) begin
            depth_q <= depth_q + PcW'(1);
          end
          if ((fwd_q && ch == bfi_pkg::ChClose) || (!fwd_q && ch == bfi_pkg::ChOpen))
          begin
            depth_q <= depth_q - PcW'(1);
          end
          if (((fwd_q && ch == bfi_pkg::ChClose) || (!fwd_q && ch == bfi_pkg::ChOpen))
              && depth_q == '0) begin
            pc_q    <= p_q + PcW'(1);
            state_q <= SPush;
          end else if (fwd_q ? (p_q < last_ext) : (p_q != '0)) begin
            state_q <= SScanRd;
          end else begin
            st_q    <= fwd_q ? bfi_pkg::StOpenErr : bfi_pkg::StCloseErr;
            err_q   <= 1'b1;
            code_q  <= fwd_q ? bfi_pkg::StOpenErr : bfi_pkg::StCloseErr;
            state_q <= SPush;
          end
        end
        SPush: begin
          if (!rvld_q || rsp_o.ready) begin
            rvld_q  <= 1'b1;
            state_q <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && head_i.valid) begin
      ent_q <= head_i.item;
    end
    if (state_q == SPush && (!rvld_q || rsp_o.ready)) begin
      rsp_q.out_valid        <= ov_q;
      rsp_q.out_char         <= oc_q;
      rsp_q.halted           <= (pc_q > last_ext);
      rsp_q.status           <= 3'(st_q);
      rsp_q.next_pc          <= pc_q;
      rsp_q.cell_pointer_out <= 12'(ptr_q);
    end
  end

  assign rsp_o.valid = rvld_q;
  assign rsp_o.data  = rsp_q;
endmodule

### hw/rtl/brainfuck_interpreter_core_top.sv
`timescale 1ns / 1ps
// Sequence: a load goes from queue head through the idle and push states to the
// result register; an executed step also passes the execute state, and a bracket
// scan adds a read and a check state per program character walked. Throughput:
// one item at a time in the execution side, set by its state machine; a two-entry
// queue and an output register absorb stalls. Reset: state clears at once, then a
// pass zeroes the tape, during which no item is accepted (configuration writes still are).
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core_top
// Interpreter core: request queue in front, instruction executor behind.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core_top #(
  parameter int unsigned PROG_DEPTH = 4096,
  parameter int unsigned TAPE_CELLS = 4096
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfi_req_if.sink   req_i,
  bfi_cfg_if.sink   cfg_i,
  bfi_rsp_if.source rsp_o
);
  bfi_pkg::qhead_t head;
  logic            pop;
  logic            open;

  bfi_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .open_i (open),
    .req_i  (req_i),
    .pop_i  (pop),
    .head_o (head)
  );

  bfi_back #(.PROG_DEPTH(PROG_DEPTH), .TAPE_CELLS(TAPE_CELLS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .pop_o   (pop),
    .ready_o (open),
    .cfg_i   (cfg_i),
    .rsp_o   (rsp_o)
  );
endmodule

### hw/rtl/bfi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_checker
// Port-level checks of the interpreter core's result stream.
// ----------------------------------------------------------------------------
module bfi_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bfi_pkg::rsp_t rsp_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_data.out_valid |-> rsp_data.out_char == 8'h00)
    else $error("output byte without dot");

  a_halt_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.halted |-> rsp_data.next_pc != '0)
    else $error("halted with pc at zero");

  a_bracket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && (rsp_data.status == 3'(bfi_pkg::StOpenErr) ||
                  rsp_data.status == 3'(bfi_pkg::StCloseErr)) |-> !rsp_data.halted)
    else $error("bracket error past end of program");
endmodule

bind brainfuck_interpreter_core_top bfi_checker u_bfi_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .rsp_data  (rsp_o.data)
);
